// ===== rtl/core/vts_pkg.sv =====
// vts_pkg: shared constants and codes for the volume trilinear sampler
// used by vts_blend and volume_trilinear_sampler_top; no dependencies
package vts_pkg;

	// fixed field widths
	localparam int PIX_W     = 8;
	localparam int POS_W     = 16;
	localparam int CFG_W     = 7;
	localparam int CFG_IDX_W = 2;

	// default volume geometry and fixed-point format
	localparam int DEF_MAX_WIDTH  = 64;
	localparam int DEF_MAX_HEIGHT = 64;
	localparam int DEF_MAX_SLICES = 16;
	localparam int DEF_FRAC_BITS  = 8;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_USED  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_USED = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SLICES_USED = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_INTERP_MODE = 2'd3;

	// register reset values
	localparam logic [6:0] RST_WIDTH_USED  = 7'd64;
	localparam logic [6:0] RST_HEIGHT_USED = 7'd64;
	localparam logic [4:0] RST_SLICES_USED = 5'd16;

	// request function and sampling mode codes
	typedef enum logic {
		FUNC_WRITE  = 1'b0,
		FUNC_SAMPLE = 1'b1
	} func_t;

	typedef enum logic {
		MODE_TRILINEAR = 1'b0,
		MODE_NEAREST   = 1'b1
	} interp_mode_t;

endpackage

// ===== rtl/core/vts_blend.sv =====
// vts_blend: one registered linear blend stage, (a*(ONE-f) + b*f) >> FRAC_BITS
// depends on vts_pkg for the pixel width and the default fraction bits
module vts_blend
	import vts_pkg::*;
#(
	parameter int FRAC_BITS = DEF_FRAC_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 go,
	input  logic [PIX_W-1:0]     a,
	input  logic [PIX_W-1:0]     b,
	input  logic [FRAC_BITS-1:0] frac,
	output logic                 res_valid,
	output logic [PIX_W-1:0]     res
);

	localparam int WGT_W  = FRAC_BITS + 1;
	localparam int PROD_W = PIX_W + WGT_W;
	localparam int SUM_W  = PROD_W + 1;
	localparam logic [WGT_W-1:0] ONE = WGT_W'(1) << FRAC_BITS;

	logic [WGT_W-1:0]  wgt_a;
	logic [WGT_W-1:0]  wgt_b;
	logic [PROD_W-1:0] prod_a;
	logic [PROD_W-1:0] prod_b;
	logic [SUM_W-1:0]  sum;
	logic              valid_q;
	logic [PIX_W-1:0]  res_q;

	// weighted sum of the two neighbors
	always_comb begin
		wgt_b  = {1'b0, frac};
		wgt_a  = ONE - wgt_b;
		prod_a = PROD_W'(a) * PROD_W'(wgt_a);
		prod_b = PROD_W'(b) * PROD_W'(wgt_b);
		sum    = SUM_W'(prod_a) + SUM_W'(prod_b);
	end

	// result register, floored to pixel width
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= go;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			res_q <= PIX_W'(sum >> FRAC_BITS);
		end
	end

	assign res_valid = valid_q;
	assign res       = res_q;

endmodule

// ===== rtl/core/volume_trilinear_sampler_top.sv =====
// volume_trilinear_sampler_top: voxel memory, corner read sequencer and blend tree
// depends on vts_pkg and vts_blend
//
// Usage:
//   Input channel (in_valid/in_ready) carries one request: func selects a
//   pixel write or a volume sample; positions are signed fixed point with
//   FRAC_BITS fraction bits. Writes use the floor of each position and are
//   dropped outside the configured size; they give no result.
//   Output channel (out_valid/out_ready) carries one pixel_out per sample.
//   Configuration (cfg_we, cfg_index, cfg_data) sets the volume size and the
//   sampling mode; write it only while no request is in progress.
// Sequencing:
//   One request is in progress at a time. A write passes through the
//   write state and then returns to idle. A nearest sample reads one voxel;
//   a trilinear sample reads eight corners from the single read port of the
//   voxel memory, one per cycle, then passes the x, y and z blend stages.
//   A finished result waits in the output register while the next request
//   is taken; a sample starts its reads only once that register is free or
//   being drained, so a stalled receiver holds off new samples.
// Reset: control and configuration registers return to their defaults; voxel
//   contents are undefined until written and there is no clearing pass.
module volume_trilinear_sampler_top
	import vts_pkg::*;
#(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
	parameter int MAX_SLICES = DEF_MAX_SLICES,
	parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
	input  logic                    clk,
	input  logic                    arst_n,
	// request channel
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic                    func,
	input  logic signed [POS_W-1:0] col_pos,
	input  logic signed [POS_W-1:0] row_pos,
	input  logic signed [POS_W-1:0] slice_pos,
	input  logic [PIX_W-1:0]        pixel_in,
	// result channel
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [PIX_W-1:0]        pixel_out,
	// configuration port
	input  logic                    cfg_we,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_W-1:0]        cfg_data
);

	localparam int CRD_W  = POS_W + 2;
	localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT * MAX_SLICES;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CI_W   = $clog2(MAX_WIDTH);
	localparam int RI_W   = $clog2(MAX_HEIGHT);
	localparam int SI_W   = (MAX_SLICES > 1) ? $clog2(MAX_SLICES) : 1;
	localparam logic [ADDR_W-1:0] ROW_STRIDE   = ADDR_W'(MAX_WIDTH);
	localparam logic [ADDR_W-1:0] SLICE_STRIDE = ADDR_W'(MAX_WIDTH * MAX_HEIGHT);
	localparam logic signed [CRD_W-1:0] LIM_C = CRD_W'(MAX_WIDTH);
	localparam logic signed [CRD_W-1:0] LIM_R = CRD_W'(MAX_HEIGHT);
	localparam logic signed [CRD_W-1:0] LIM_S = CRD_W'(MAX_SLICES);
	localparam logic signed [CRD_W-1:0] HALF  = CRD_W'(1) <<< (FRAC_BITS - 1);
	localparam logic [2:0] LAST_TRI = 3'd7;
	localparam logic [2:0] LAST_NN  = 3'd0;

	typedef enum logic [1:0] {
		S_IDLE,
		S_WRITE,
		S_READ,
		S_FINISH
	} state_t;

	// configuration registers
	logic [6:0] width_used_q;
	logic [6:0] height_used_q;
	logic [4:0] slices_used_q;
	logic       interp_mode_q;

	// request registers
	state_t                     state_q;
	logic [2:0]                 corner_q;
	logic                       nearest_q;
	logic signed [CRD_W-1:0]    base_c_q;
	logic signed [CRD_W-1:0]    base_r_q;
	logic signed [CRD_W-1:0]    base_s_q;
	logic [FRAC_BITS-1:0]       fx_q;
	logic [FRAC_BITS-1:0]       fy_q;
	logic [FRAC_BITS-1:0]       fz_q;
	logic [PIX_W-1:0]           wr_pixel_q;

	// memory and read stage
	logic [PIX_W-1:0]  voxel_mem [DEPTH];
	logic [PIX_W-1:0]  rd_data_s1;
	logic              rd_valid_s1;
	logic              rd_inside_s1;
	logic              rd_odd_s1;

	// blend tree holding registers
	logic [PIX_W-1:0] x_lo_q;
	logic [PIX_W-1:0] y_lo_q;
	logic [PIX_W-1:0] z_lo_q;
	logic             y_tog_q;
	logic             z_tog_q;

	logic                    out_valid_q;
	logic [PIX_W-1:0]        pixel_out_q;

	logic                    accept;
	logic                    is_sample;
	logic                    use_half;
	logic signed [CRD_W-1:0] pos_c;
	logic signed [CRD_W-1:0] pos_r;
	logic signed [CRD_W-1:0] pos_s;
	logic signed [CRD_W-1:0] cur_c;
	logic signed [CRD_W-1:0] cur_r;
	logic signed [CRD_W-1:0] cur_s;
	logic                    cur_inside;
	logic [ADDR_W-1:0]       cur_addr;
	logic                    issue;
	logic                    mem_we;
	logic [2:0]              last_corner;
	logic [PIX_W-1:0]        rd_val;
	logic                    x_go;
	logic                    x_valid;
	logic [PIX_W-1:0]        x_res;
	logic                    y_go;
	logic                    y_valid;
	logic [PIX_W-1:0]        y_res;
	logic                    z_go;
	logic                    z_valid;
	logic [PIX_W-1:0]        z_res;
	logic                    res_load;
	logic [PIX_W-1:0]        res_val;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;

	// position with rounding offset for nearest sampling
	always_comb begin
		is_sample = (func == FUNC_SAMPLE);
		use_half  = is_sample && (interp_mode_q == MODE_NEAREST);
		pos_c = CRD_W'(col_pos) + (use_half ? HALF : '0);
		pos_r = CRD_W'(row_pos) + (use_half ? HALF : '0);
		pos_s = CRD_W'(slice_pos) + (use_half ? HALF : '0);
	end

	// corner coordinates, bounds check and memory address
	always_comb begin
		cur_c = base_c_q + $signed({{(CRD_W-1){1'b0}}, corner_q[0]});
		cur_r = base_r_q + $signed({{(CRD_W-1){1'b0}}, corner_q[1]});
		cur_s = base_s_q + $signed({{(CRD_W-1){1'b0}}, corner_q[2]});
		cur_inside = (cur_c >= 0) && (cur_c < LIM_C)
			&& (cur_c < $signed({{(CRD_W-7){1'b0}}, width_used_q}))
			&& (cur_r >= 0) && (cur_r < LIM_R)
			&& (cur_r < $signed({{(CRD_W-7){1'b0}}, height_used_q}))
			&& (cur_s >= 0) && (cur_s < LIM_S)
			&& (cur_s < $signed({{(CRD_W-5){1'b0}}, slices_used_q}));
		cur_addr = ADDR_W'(cur_s[SI_W-1:0]) * SLICE_STRIDE
			+ ADDR_W'(cur_r[RI_W-1:0]) * ROW_STRIDE
			+ ADDR_W'(cur_c[CI_W-1:0]);
	end

	// read issue waits for a free output register at the first corner
	always_comb begin
		last_corner = nearest_q ? LAST_NN : LAST_TRI;
		issue  = (state_q == S_READ)
			&& ((corner_q != 3'd0) || !out_valid_q || out_ready);
		mem_we = (state_q == S_WRITE) && cur_inside;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_used_q  <= RST_WIDTH_USED;
			height_used_q <= RST_HEIGHT_USED;
			slices_used_q <= RST_SLICES_USED;
			interp_mode_q <= MODE_TRILINEAR;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_WIDTH_USED:  width_used_q  <= cfg_data;
				CFG_HEIGHT_USED: height_used_q <= cfg_data;
				CFG_SLICES_USED: slices_used_q <= cfg_data[4:0];
				CFG_INTERP_MODE: interp_mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// request sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			corner_q  <= 3'd0;
			nearest_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					corner_q <= 3'd0;
					if (accept) begin
						nearest_q <= use_half;
						state_q   <= is_sample ? S_READ : S_WRITE;
					end
				end
				S_WRITE: begin
					state_q <= S_IDLE;
				end
				S_READ: begin
					if (issue) begin
						corner_q <= corner_q + 3'd1;
						if (corner_q == last_corner) begin
							state_q <= S_FINISH;
						end
					end
				end
				S_FINISH: begin
					if (res_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// request payload capture
	always_ff @(posedge clk) begin
		if (accept) begin
			base_c_q   <= pos_c >>> FRAC_BITS;
			base_r_q   <= pos_r >>> FRAC_BITS;
			base_s_q   <= pos_s >>> FRAC_BITS;
			fx_q       <= pos_c[FRAC_BITS-1:0];
			fy_q       <= pos_r[FRAC_BITS-1:0];
			fz_q       <= pos_s[FRAC_BITS-1:0];
			wr_pixel_q <= pixel_in;
		end
	end

	// voxel memory, one port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			voxel_mem[cur_addr] <= wr_pixel_q;
		end
		rd_data_s1 <= voxel_mem[cur_addr];
	end

	// read stage tags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			rd_inside_s1 <= cur_inside;
			rd_odd_s1    <= corner_q[0];
		end
	end

	// out-of-volume corners read as zero
	assign rd_val = rd_inside_s1 ? rd_data_s1 : '0;

	// pairing of blend operands along x, y and z
	assign x_go = rd_valid_s1 && !nearest_q && rd_odd_s1;
	assign y_go = x_valid && y_tog_q;
	assign z_go = y_valid && z_tog_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			y_tog_q <= 1'b0;
			z_tog_q <= 1'b0;
		end else begin
			if (x_valid) begin
				y_tog_q <= !y_tog_q;
			end
			if (y_valid) begin
				z_tog_q <= !z_tog_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_valid_s1 && !rd_odd_s1) begin
			x_lo_q <= rd_val;
		end
		if (x_valid && !y_tog_q) begin
			y_lo_q <= x_res;
		end
		if (y_valid && !z_tog_q) begin
			z_lo_q <= y_res;
		end
	end

	vts_blend #(
		.FRAC_BITS(FRAC_BITS)
	) u_blend_x (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (x_go),
		.a         (x_lo_q),
		.b         (rd_val),
		.frac      (fx_q),
		.res_valid (x_valid),
		.res       (x_res)
	);

	vts_blend #(
		.FRAC_BITS(FRAC_BITS)
	) u_blend_y (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (y_go),
		.a         (y_lo_q),
		.b         (x_res),
		.frac      (fy_q),
		.res_valid (y_valid),
		.res       (y_res)
	);

	vts_blend #(
		.FRAC_BITS(FRAC_BITS)
	) u_blend_z (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (z_go),
		.a         (z_lo_q),
		.b         (y_res),
		.frac      (fz_q),
		.res_valid (z_valid),
		.res       (z_res)
	);

	// final result select
	always_comb begin
		if (nearest_q) begin
			res_load = rd_valid_s1;
			res_val  = rd_val;
		end else begin
			res_load = z_valid;
			res_val  = z_res;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			pixel_out_q <= res_val;
		end
	end

	assign out_valid = out_valid_q;
	assign pixel_out = pixel_out_q;

endmodule
